// File: sv/thc_pkg.sv
// thc_pkg: shared types, codes and constants for the thermostat heater controller.
// No dependencies; used by thc_cfg, thc_step and thermostat_heater_controller.
package thc_pkg;

  // Event codes carried by req_type
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_UP    = 2'd1,
    REQ_DOWN  = 2'd2,
    REQ_POWER = 2'd3
  } req_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_SETPOINT_MIN    = 3'd0,
    REG_SETPOINT_MAX    = 3'd1,
    REG_BAND            = 3'd2,
    REG_SAMPLE_PERIOD   = 3'd3,
    REG_SETTING_TIMEOUT = 3'd4,
    REG_BLINK_PERIOD    = 3'd5,
    REG_IDLE_OFF        = 3'd6
  } reg_idx_t;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int ADC_W   = 10;
  localparam int ADC_BITS = 10;
  localparam int TEMP_W  = 8;
  localparam int SP_W    = 7;
  localparam int BAND_W  = 5;
  localparam int TICK8_W = 8;
  localparam int TICK16_W = 16;

  localparam int AVG_COUNT_DEF = 10;
  localparam int RECIP_SHIFT   = 16;
  localparam int RECIP_W       = RECIP_SHIFT + 1;

  localparam logic [SP_W-1:0] SETPOINT_RESET = SP_W'(60);
  localparam logic [SP_W-1:0] SETPOINT_STEP  = SP_W'(5);
  localparam logic [SP_W-1:0] DISP_MAX       = SP_W'(99);

  localparam logic [SP_W-1:0]     SETPOINT_MIN_RST    = SP_W'(35);
  localparam logic [SP_W-1:0]     SETPOINT_MAX_RST    = SP_W'(75);
  localparam logic [BAND_W-1:0]   BAND_RST            = BAND_W'(5);
  localparam logic [TICK8_W-1:0]  SAMPLE_PERIOD_RST   = TICK8_W'(25);
  localparam logic [TICK16_W-1:0] SETTING_TIMEOUT_RST = TICK16_W'(1250);
  localparam logic [TICK8_W-1:0]  BLINK_PERIOD_RST    = TICK8_W'(125);
  localparam logic [TICK16_W-1:0] IDLE_OFF_RST        = TICK16_W'(60000);

  typedef struct packed {
    logic [SP_W-1:0]     setpoint_min;
    logic [SP_W-1:0]     setpoint_max;
    logic [BAND_W-1:0]   band;
    logic [TICK8_W-1:0]  sample_period;
    logic [TICK16_W-1:0] setting_timeout;
    logic [TICK8_W-1:0]  blink_period;
    logic [TICK16_W-1:0] idle_off;
  } cfg_t;

  // Controller state, apart from the averaging accumulator
  typedef struct packed {
    logic                power_on;
    logic                setting_active;
    logic [SP_W-1:0]     setpoint;
    logic [TEMP_W-1:0]   tank_temp;
    logic [TICK8_W-1:0]  sample_ticks;
    logic [TICK16_W-1:0] setting_ticks;
    logic [TICK8_W-1:0]  blink_ticks;
    logic                blink_phase;
    logic                heating;
    logic                cooling;
    logic                reached;
    logic [TICK16_W-1:0] reached_ticks;
    logic                heat_led_state;
  } st_t;

  typedef struct packed {
    logic            heater_en;
    logic            cooler_on;
    logic            power_led;
    logic            heat_led;
    logic [SP_W-1:0] display_value;
    logic            display_blank;
  } res_t;

endpackage

// File: sv/thermostat_heater_controller.sv
// thermostat_heater_controller: top level of the bang-bang thermostat with hysteresis.
// Depends on thc_pkg, thc_cfg and thc_step.
//
// One event beat in, one result beat out. Each beat carries a timer tick or an
// up/down/power button press together with a raw converter sample; the result
// gives the heater and cooler drives, the power and element LEDs and the
// two-digit display. While in_stall is low the block takes a new beat every clock
// cycle: a beat sits in an input register, the whole control step for it is
// evaluated in one pass of logic (the divide by AVG_COUNT is a constant reciprocal
// multiply), and the result lands in an output register, so throughput is one
// beat per cycle while out_stall is low. A held result (out_stall high)
// stops the step and the input register, and in_stall rises only once the input
// register is also full. There is no clearing pass after reset. Configuration
// registers sit on the APB-style cfg_ port at byte addresses 4*i and should be
// written only while no beat is in flight.
module thermostat_heater_controller #(
  parameter int AVG_COUNT = thc_pkg::AVG_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // event channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [thc_pkg::ADC_W-1:0]   in_adc_sample,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_heater_en,
  output logic                        out_cooler_on,
  output logic                        out_power_led,
  output logic                        out_heat_led,
  output logic [thc_pkg::SP_W-1:0]    out_display_value,
  output logic                        out_display_blank,
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [thc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [thc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [thc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int SUM_W = $clog2(AVG_COUNT * 255 + 1);
  localparam int CNT_W = $clog2(AVG_COUNT + 1);

  thc_pkg::cfg_t cfg;

  // input register
  logic                       s1_valid_r;
  logic [1:0]                 s1_req_r;
  logic [thc_pkg::ADC_W-1:0]  s1_adc_r;

  // controller state
  thc_pkg::st_t     st_r, st_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // result register
  logic             out_valid_r;
  thc_pkg::res_t    res_r, res_nxt;

  logic move;     // result register free to load this cycle
  logic fire;     // beat in the input register is being processed
  logic in_acc;

  assign move     = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && move;
  assign in_stall = s1_valid_r && !move;
  assign in_acc   = in_valid && !in_stall;

  thc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  thc_step #(
    .AVG_COUNT (AVG_COUNT),
    .SUM_W     (SUM_W),
    .CNT_W     (CNT_W)
  ) u_step (
    .req_type   (s1_req_r),
    .adc_sample (s1_adc_r),
    .cfg        (cfg),
    .st         (st_r),
    .sum        (sum_r),
    .cnt        (cnt_r),
    .st_nxt     (st_nxt),
    .sum_nxt    (sum_nxt),
    .cnt_nxt    (cnt_nxt),
    .res        (res_nxt)
  );

  // input register: loads whenever a beat is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_req_type;
      s1_adc_r <= in_adc_sample;
    end
  end

  // controller state advances once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.power_on       <= 1'b0;
      st_r.setting_active <= 1'b0;
      st_r.setpoint       <= thc_pkg::SETPOINT_RESET;
      st_r.tank_temp      <= '0;
      st_r.sample_ticks   <= '0;
      st_r.setting_ticks  <= '0;
      st_r.blink_ticks    <= '0;
      st_r.blink_phase    <= 1'b0;
      st_r.heating        <= 1'b0;
      st_r.cooling        <= 1'b0;
      st_r.reached        <= 1'b0;
      st_r.reached_ticks  <= '0;
      st_r.heat_led_state <= 1'b0;
      sum_r               <= '0;
      cnt_r               <= '0;
    end else if (fire) begin
      st_r  <= st_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_heater_en     = res_r.heater_en;
  assign out_cooler_on     = res_r.cooler_on;
  assign out_power_led     = res_r.power_led;
  assign out_heat_led      = res_r.heat_led;
  assign out_display_value = res_r.display_value;
  assign out_display_blank = res_r.display_blank;

  // heater and cooler are never driven together
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.heater_en && res_r.cooler_on))
    else $error("heater and cooler both on");

  // unit off means both elements and the element LED are off
  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.power_led) |->
      (!res_r.heater_en && !res_r.cooler_on && !res_r.heat_led))
    else $error("element active while powered off");

  // setting mode only exists while powered off
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.setting_active && st_r.power_on))
    else $error("setting mode while powered on");

  // a processed beat always produces a valid result next cycle
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed beat produced no result");

endmodule

// File: sv/thc_cfg.sv
// thc_cfg: APB-style register file for the thermostat limits and timers.
// Depends on thc_pkg.
module thc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [thc_pkg::ADDR_W-1:0]   paddr,
  input  logic [thc_pkg::DATA_W-1:0]   pwdata,
  output logic [thc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output thc_pkg::cfg_t                cfg
);

  thc_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[thc_pkg::ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_min    <= thc_pkg::SETPOINT_MIN_RST;
      cfg_r.setpoint_max    <= thc_pkg::SETPOINT_MAX_RST;
      cfg_r.band            <= thc_pkg::BAND_RST;
      cfg_r.sample_period   <= thc_pkg::SAMPLE_PERIOD_RST;
      cfg_r.setting_timeout <= thc_pkg::SETTING_TIMEOUT_RST;
      cfg_r.blink_period    <= thc_pkg::BLINK_PERIOD_RST;
      cfg_r.idle_off        <= thc_pkg::IDLE_OFF_RST;
    end else if (wr_en) begin
      case (thc_pkg::reg_idx_t'(idx))
        thc_pkg::REG_SETPOINT_MIN:    cfg_r.setpoint_min    <= pwdata[thc_pkg::SP_W-1:0];
        thc_pkg::REG_SETPOINT_MAX:    cfg_r.setpoint_max    <= pwdata[thc_pkg::SP_W-1:0];
        thc_pkg::REG_BAND:            cfg_r.band            <= pwdata[thc_pkg::BAND_W-1:0];
        thc_pkg::REG_SAMPLE_PERIOD:   cfg_r.sample_period   <= pwdata[thc_pkg::TICK8_W-1:0];
        thc_pkg::REG_SETTING_TIMEOUT: cfg_r.setting_timeout <= pwdata[thc_pkg::TICK16_W-1:0];
        thc_pkg::REG_BLINK_PERIOD:    cfg_r.blink_period    <= pwdata[thc_pkg::TICK8_W-1:0];
        thc_pkg::REG_IDLE_OFF:        cfg_r.idle_off        <= pwdata[thc_pkg::TICK16_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (thc_pkg::reg_idx_t'(idx))
      thc_pkg::REG_SETPOINT_MIN:    prdata = thc_pkg::DATA_W'(cfg_r.setpoint_min);
      thc_pkg::REG_SETPOINT_MAX:    prdata = thc_pkg::DATA_W'(cfg_r.setpoint_max);
      thc_pkg::REG_BAND:            prdata = thc_pkg::DATA_W'(cfg_r.band);
      thc_pkg::REG_SAMPLE_PERIOD:   prdata = thc_pkg::DATA_W'(cfg_r.sample_period);
      thc_pkg::REG_SETTING_TIMEOUT: prdata = thc_pkg::DATA_W'(cfg_r.setting_timeout);
      thc_pkg::REG_BLINK_PERIOD:    prdata = thc_pkg::DATA_W'(cfg_r.blink_period);
      thc_pkg::REG_IDLE_OFF:        prdata = thc_pkg::DATA_W'(cfg_r.idle_off);
      default:                      prdata = '0;
    endcase
  end

endmodule

// File: sv/thc_step.sv
// thc_step: single-pass next-state and result logic for one event beat.
// Depends on thc_pkg. Purely combinational.
module thc_step #(
  parameter int AVG_COUNT = thc_pkg::AVG_COUNT_DEF,
  parameter int SUM_W     = $clog2(AVG_COUNT * 255 + 1),
  parameter int CNT_W     = $clog2(AVG_COUNT + 1)
) (
  input  logic [1:0]                 req_type,
  input  logic [thc_pkg::ADC_W-1:0]  adc_sample,
  input  thc_pkg::cfg_t              cfg,
  input  thc_pkg::st_t               st,
  input  logic [SUM_W-1:0]           sum,
  input  logic [CNT_W-1:0]           cnt,
  output thc_pkg::st_t               st_nxt,
  output logic [SUM_W-1:0]           sum_nxt,
  output logic [CNT_W-1:0]           cnt_nxt,
  output thc_pkg::res_t              res
);

  // Exact divide by AVG_COUNT for sums below 2^12 via a rounded-up reciprocal
  localparam int RECIP  = ((1 << thc_pkg::RECIP_SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
  localparam int PROD_W = SUM_W + thc_pkg::RECIP_W;
  localparam logic [thc_pkg::ADC_W-1:0] ADC_MASK =
    (thc_pkg::ADC_BITS >= thc_pkg::ADC_W) ? {thc_pkg::ADC_W{1'b1}} :
    thc_pkg::ADC_W'((1 << thc_pkg::ADC_BITS) - 1);

  logic [thc_pkg::ADC_W-1:0]  adc_m;
  logic [thc_pkg::TEMP_W-1:0] temp;
  logic [PROD_W-1:0]          prod;

  assign adc_m = adc_sample & ADC_MASK;
  assign temp  = adc_m[thc_pkg::ADC_W-1:2];

  always_comb begin
    thc_pkg::st_t             s;
    logic [SUM_W-1:0]         sm;
    logic [CNT_W-1:0]         cn;
    logic                     tick;
    logic [thc_pkg::TEMP_W:0] hi;
    logic [thc_pkg::TEMP_W:0] t_pb;
    logic [thc_pkg::TEMP_W:0] sp_ext;
    logic [thc_pkg::TEMP_W:0] t_ext;
    logic [thc_pkg::SP_W:0]   sp_up;
    logic [thc_pkg::SP_W:0]   min_up;
    logic [thc_pkg::SP_W-1:0] disp;
    logic [thc_pkg::TEMP_W-1:0] dtemp;

    s    = st;
    sm   = sum;
    cn   = cnt;
    prod = '0;
    tick = (thc_pkg::req_t'(req_type) == thc_pkg::REQ_TICK) &&
           (st.power_on || st.setting_active);

    // tick timers, all saturating
    if (tick) begin
      if (s.sample_ticks != '1) s.sample_ticks = s.sample_ticks + 1'b1;
      if (s.setting_active) begin
        if (s.setting_ticks != '1) s.setting_ticks = s.setting_ticks + 1'b1;
        if (s.blink_ticks != '1)   s.blink_ticks   = s.blink_ticks + 1'b1;
      end else if (s.power_on) begin
        if (s.heating) begin
          if (s.blink_ticks != '1) s.blink_ticks = s.blink_ticks + 1'b1;
        end else if (s.reached) begin
          if (s.reached_ticks != '1) s.reached_ticks = s.reached_ticks + 1'b1;
        end
      end
    end

    // buttons while off: enter setting mode, then step setpoint
    sp_up  = {1'b0, s.setpoint} + {1'b0, thc_pkg::SETPOINT_STEP};
    min_up = {1'b0, cfg.setpoint_min} + {1'b0, thc_pkg::SETPOINT_STEP};
    if (!s.power_on) begin
      s.tank_temp = temp;
      if ((thc_pkg::req_t'(req_type) == thc_pkg::REQ_UP) ||
          (thc_pkg::req_t'(req_type) == thc_pkg::REQ_DOWN)) begin
        if (!s.setting_active) begin
          s.setting_active = 1'b1;
        end else if (thc_pkg::req_t'(req_type) == thc_pkg::REQ_UP) begin
          if (sp_up <= {1'b0, cfg.setpoint_max}) s.setpoint = sp_up[thc_pkg::SP_W-1:0];
        end else begin
          if ({1'b0, s.setpoint} >= min_up)
            s.setpoint = s.setpoint - thc_pkg::SETPOINT_STEP;
        end
        s.setting_ticks = '0;
      end
    end

    if (thc_pkg::req_t'(req_type) == thc_pkg::REQ_POWER) begin
      if (s.power_on) begin
        s.power_on = 1'b0;
      end else begin
        s.power_on       = 1'b1;
        s.setting_active = 1'b0;
        s.setting_ticks  = '0;
      end
    end

    // sample averaging
    if (s.sample_ticks >= cfg.sample_period) begin
      sm = sm + SUM_W'(temp);
      cn = cn + 1'b1;
      if (cn >= CNT_W'(AVG_COUNT)) begin
        prod = PROD_W'(sm) * PROD_W'(RECIP);
        // average of 8-bit samples never exceeds 255
        s.tank_temp = prod[thc_pkg::RECIP_SHIFT +: thc_pkg::TEMP_W];
        sm = '0;
        cn = '0;
      end
      s.sample_ticks = '0;
    end

    if (s.setting_active && (s.setting_ticks >= cfg.setting_timeout)) begin
      s.setting_active = 1'b0;
      s.power_on       = 1'b1;
      s.setting_ticks  = '0;
    end

    if (s.blink_ticks >= cfg.blink_period) begin
      if (s.setting_active)             s.blink_phase    = ~s.blink_phase;
      else if (s.heating && s.power_on) s.heat_led_state = ~s.heat_led_state;
      s.blink_ticks = '0;
    end
    if (s.cooling && s.power_on) s.heat_led_state = 1'b1;

    if ((s.reached_ticks >= cfg.idle_off) && s.power_on && s.reached) begin
      s.power_on      = 1'b0;
      s.reached_ticks = '0;
    end

    // hysteresis control; lo comparisons done as t + band against setpoint
    t_ext  = {1'b0, s.tank_temp};
    sp_ext = {2'b0, s.setpoint};
    hi     = sp_ext + {4'b0, cfg.band};
    t_pb   = t_ext + {4'b0, cfg.band};
    if (s.power_on) begin
      if ((t_ext < hi) && (t_pb > sp_ext) && !s.cooling && !s.heating && !s.reached) begin
        s.reached       = 1'b1;
        s.reached_ticks = '0;
      end else if ((s.heating && (t_ext >= hi)) || (s.cooling && (t_pb <= sp_ext))) begin
        s.heat_led_state = 1'b0;
        s.heating        = 1'b0;
        s.cooling        = 1'b0;
        s.reached        = 1'b1;
        s.reached_ticks  = '0;
      end else if (t_pb < sp_ext) begin
        s.heating       = 1'b1;
        s.cooling       = 1'b0;
        s.reached_ticks = '0;
      end else if (t_ext > hi) begin
        s.cooling       = 1'b1;
        s.heating       = 1'b0;
        s.reached_ticks = '0;
      end
    end else begin
      s.heating        = 1'b0;
      s.cooling        = 1'b0;
      s.reached        = 1'b0;
      s.heat_led_state = 1'b0;
    end

    // display
    dtemp = (s.tank_temp > thc_pkg::TEMP_W'(thc_pkg::DISP_MAX)) ?
            thc_pkg::TEMP_W'(thc_pkg::DISP_MAX) : s.tank_temp;
    if (s.power_on && !s.setting_active) begin
      disp = dtemp[thc_pkg::SP_W-1:0];
    end else begin
      disp = (s.setpoint > thc_pkg::DISP_MAX) ? thc_pkg::DISP_MAX : s.setpoint;
    end

    res.heater_en     = s.heating;
    res.cooler_on     = s.cooling;
    res.power_led     = s.power_on;
    res.heat_led      = s.heat_led_state;
    res.display_value = disp;
    res.display_blank = s.setting_active & s.blink_phase;

    st_nxt  = s;
    sum_nxt = sm;
    cnt_nxt = cn;
  end

endmodule

// File: verif/thc_panel_check.sv
`timescale 1ns / 1ps
// thc_panel_check: watches the event, result and register ports of the thermostat
// heater controller, predicts every result beat and compares it. Depends on thc_pkg.
module thc_panel_check #(
  parameter int AVG_N = thc_pkg::AVG_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [thc_pkg::ADC_W-1:0]  in_adc_sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_heater_en,
  input  logic                       out_cooler_on,
  input  logic                       out_power_led,
  input  logic                       out_heat_led,
  input  logic [thc_pkg::SP_W-1:0]   out_display_value,
  input  logic                       out_display_blank,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [thc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [thc_pkg::DATA_W-1:0] cfg_pwdata,
  output int                         mismatches,
  output int                         backlog
);

  thc_pkg::cfg_t limits;
  thc_pkg::st_t  thermo;
  logic [11:0]   avg_sum;
  logic [3:0]    avg_cnt;
  thc_pkg::res_t predicted_panel[$];
  thc_pkg::res_t want;
  int            fails = 0;

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endtask

  // One control step of the thermostat; updates thermo and returns the panel.
  function automatic thc_pkg::res_t next_panel(input thc_pkg::req_t req,
                                               input logic [thc_pkg::ADC_W-1:0] adc);
    logic [thc_pkg::TEMP_W-1:0] temp;
    int   t, hi, lo, avg, shown;
    thc_pkg::res_t r;
    temp = adc[thc_pkg::ADC_W-1:2];

    // tick timer runs only while on or in setting mode
    if (req == thc_pkg::REQ_TICK && (thermo.power_on || thermo.setting_active)) begin
      if (thermo.sample_ticks != '1) thermo.sample_ticks++;
      if (thermo.setting_active) begin
        if (thermo.setting_ticks != '1) thermo.setting_ticks++;
        if (thermo.blink_ticks != '1) thermo.blink_ticks++;
      end else if (thermo.power_on) begin
        if (thermo.heating) begin
          if (thermo.blink_ticks != '1) thermo.blink_ticks++;
        end else if (thermo.reached) begin
          if (thermo.reached_ticks != '1) thermo.reached_ticks++;
        end
      end
    end

    if (!thermo.power_on) begin
      thermo.tank_temp = temp;
      if (req == thc_pkg::REQ_UP || req == thc_pkg::REQ_DOWN) begin
        if (!thermo.setting_active) begin
          thermo.setting_active = 1'b1;
        end else if (req == thc_pkg::REQ_UP) begin
          if (int'(thermo.setpoint) + 5 <= int'(limits.setpoint_max))
            thermo.setpoint = thermo.setpoint + thc_pkg::SETPOINT_STEP;
        end else begin
          if (int'(thermo.setpoint) >= int'(limits.setpoint_min) + 5)
            thermo.setpoint = thermo.setpoint - thc_pkg::SETPOINT_STEP;
        end
        thermo.setting_ticks = '0;
      end
    end

    if (req == thc_pkg::REQ_POWER) begin
      if (thermo.power_on) begin
        thermo.power_on = 1'b0;
      end else begin
        thermo.power_on       = 1'b1;
        thermo.setting_active = 1'b0;
        thermo.setting_ticks  = '0;
      end
    end

    if (thermo.sample_ticks >= limits.sample_period) begin
      avg_sum = avg_sum + temp;
      avg_cnt++;
      if (avg_cnt >= AVG_N) begin
        avg = avg_sum / AVG_N;
        thermo.tank_temp = (avg > 255) ? 8'd255 : thc_pkg::TEMP_W'(avg);
        avg_sum = '0;
        avg_cnt = '0;
      end
      thermo.sample_ticks = '0;
    end

    if (thermo.setting_active && thermo.setting_ticks >= limits.setting_timeout) begin
      thermo.setting_active = 1'b0;
      thermo.power_on       = 1'b1;
      thermo.setting_ticks  = '0;
    end

    if (thermo.blink_ticks >= limits.blink_period) begin
      if (thermo.setting_active)
        thermo.blink_phase = ~thermo.blink_phase;
      else if (thermo.heating && thermo.power_on)
        thermo.heat_led_state = ~thermo.heat_led_state;
      thermo.blink_ticks = '0;
    end
    if (thermo.cooling && thermo.power_on) thermo.heat_led_state = 1'b1;

    if (thermo.reached_ticks >= limits.idle_off && thermo.power_on && thermo.reached) begin
      thermo.power_on      = 1'b0;
      thermo.reached_ticks = '0;
    end

    if (thermo.power_on) begin
      t  = int'(thermo.tank_temp);
      hi = int'(thermo.setpoint) + int'(limits.band);
      lo = int'(thermo.setpoint) - int'(limits.band);
      if (t < hi && t > lo && !thermo.cooling && !thermo.heating && !thermo.reached) begin
        thermo.reached       = 1'b1;
        thermo.reached_ticks = '0;
      end else if ((thermo.heating && t >= hi) || (thermo.cooling && t <= lo)) begin
        thermo.heat_led_state = 1'b0;
        thermo.heating        = 1'b0;
        thermo.cooling        = 1'b0;
        thermo.reached        = 1'b1;
        thermo.reached_ticks  = '0;
      end else if (t < lo) begin
        thermo.heating       = 1'b1;
        thermo.cooling       = 1'b0;
        thermo.reached_ticks = '0;
      end else if (t > hi) begin
        thermo.cooling       = 1'b1;
        thermo.heating       = 1'b0;
        thermo.reached_ticks = '0;
      end
    end else begin
      thermo.heating        = 1'b0;
      thermo.cooling        = 1'b0;
      thermo.reached        = 1'b0;
      thermo.heat_led_state = 1'b0;
    end

    r.display_blank = 1'b0;
    if (thermo.setting_active) begin
      shown = int'(thermo.setpoint);
      r.display_blank = thermo.blink_phase;
    end else if (thermo.power_on) begin
      shown = int'(thermo.tank_temp);
    end else begin
      shown = int'(thermo.setpoint);
    end
    if (shown > int'(thc_pkg::DISP_MAX)) shown = int'(thc_pkg::DISP_MAX);
    r.display_value = thc_pkg::SP_W'(shown);
    r.heater_en     = thermo.heating;
    r.cooler_on     = thermo.cooling;
    r.power_led     = thermo.power_on;
    r.heat_led      = thermo.heat_led_state;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thermo          = '0;
      thermo.setpoint = thc_pkg::SETPOINT_RESET;
      avg_sum         = '0;
      avg_cnt         = '0;
      limits.setpoint_min    = thc_pkg::SETPOINT_MIN_RST;
      limits.setpoint_max    = thc_pkg::SETPOINT_MAX_RST;
      limits.band            = thc_pkg::BAND_RST;
      limits.sample_period   = thc_pkg::SAMPLE_PERIOD_RST;
      limits.setting_timeout = thc_pkg::SETTING_TIMEOUT_RST;
      limits.blink_period    = thc_pkg::BLINK_PERIOD_RST;
      limits.idle_off        = thc_pkg::IDLE_OFF_RST;
      predicted_panel.delete();
      backlog    <= 0;
      mismatches <= fails;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_panel.size() == 0) begin
          $error("result beat with no event pending");
          fails++;
        end else begin
          want = predicted_panel.pop_front();
          check_field("heater_en", want.heater_en, out_heater_en);
          check_field("cooler_on", want.cooler_on, out_cooler_on);
          check_field("power_led", want.power_led, out_power_led);
          check_field("heat_led", want.heat_led, out_heat_led);
          check_field("display_value", want.display_value, out_display_value);
          check_field("display_blank", want.display_blank, out_display_blank);
        end
      end

      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (thc_pkg::reg_idx_t'(cfg_paddr[thc_pkg::ADDR_W-1:2]))
          thc_pkg::REG_SETPOINT_MIN:
            limits.setpoint_min    = cfg_pwdata[thc_pkg::SP_W-1:0];
          thc_pkg::REG_SETPOINT_MAX:
            limits.setpoint_max    = cfg_pwdata[thc_pkg::SP_W-1:0];
          thc_pkg::REG_BAND:
            limits.band            = cfg_pwdata[thc_pkg::BAND_W-1:0];
          thc_pkg::REG_SAMPLE_PERIOD:
            limits.sample_period   = cfg_pwdata[thc_pkg::TICK8_W-1:0];
          thc_pkg::REG_SETTING_TIMEOUT:
            limits.setting_timeout = cfg_pwdata[thc_pkg::TICK16_W-1:0];
          thc_pkg::REG_BLINK_PERIOD:
            limits.blink_period    = cfg_pwdata[thc_pkg::TICK8_W-1:0];
          thc_pkg::REG_IDLE_OFF:
            limits.idle_off        = cfg_pwdata[thc_pkg::TICK16_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        predicted_panel.push_back(next_panel(thc_pkg::req_t'(in_req_type), in_adc_sample));

      backlog    <= predicted_panel.size();
      mismatches <= fails;
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for thermostat_heater_controller.
// Depends on thc_pkg, the controller RTL and thc_panel_check (predict and compare).
module tb_top;

  // Slowest legal run is roughly 1350 beats; this is a wide margin over that,
  // and also bounds a hang in a drain.
  localparam int CYCLE_LIMIT = 200000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_req_type = thc_pkg::REQ_TICK;
  logic [thc_pkg::ADC_W-1:0]  in_adc_sample = '0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_heater_en;
  logic                       out_cooler_on;
  logic                       out_power_led;
  logic                       out_heat_led;
  logic [thc_pkg::SP_W-1:0]   out_display_value;
  logic                       out_display_blank;

  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [thc_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [thc_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [thc_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;

  int mismatches;
  int backlog;
  int cycles = 0;

  // sender state: beats left in the current burst, and a slowly drifting
  // water temperature (degrees) that the converter samples are built from
  int burst_left = 0;
  int water = 60;

  // receiver stall pattern: a mode held for a random stretch of cycles
  int stall_mode = 0;
  int stall_hold = 0;

  always #4 clk = ~clk;

  thermostat_heater_controller DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_adc_sample     (in_adc_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_heater_en     (out_heater_en),
    .out_cooler_on     (out_cooler_on),
    .out_power_led     (out_power_led),
    .out_heat_led      (out_heat_led),
    .out_display_value (out_display_value),
    .out_display_blank (out_display_blank),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  thc_panel_check panel_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_adc_sample     (in_adc_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_heater_en     (out_heater_en),
    .out_cooler_on     (out_cooler_on),
    .out_power_led     (out_power_led),
    .out_heat_led      (out_heat_led),
    .out_display_value (out_display_value),
    .out_display_blank (out_display_blank),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_pready        (cfg_pready),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .mismatches        (mismatches),
    .backlog           (backlog)
  );

  // Watchdog. Also catches a result beat that never shows up.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result-side backpressure. Modes: never stall, light random, heavy random,
  // and an alternating stall, so holds land on every phase of the step.
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(16, 200);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  // One register write: setup cycle, then access cycle held until pready.
  task automatic write_reg(input thc_pkg::reg_idx_t idx,
                           input logic [thc_pkg::DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input int sp_min, input int sp_max, input int hyst,
                                input int sample_p, input int set_to, input int blink_p,
                                input int idle_to);
    write_reg(thc_pkg::REG_SETPOINT_MIN, sp_min);
    write_reg(thc_pkg::REG_SETPOINT_MAX, sp_max);
    write_reg(thc_pkg::REG_BAND, hyst);
    write_reg(thc_pkg::REG_SAMPLE_PERIOD, sample_p);
    write_reg(thc_pkg::REG_SETTING_TIMEOUT, set_to);
    write_reg(thc_pkg::REG_BLINK_PERIOD, blink_p);
    write_reg(thc_pkg::REG_IDLE_OFF, idle_to);
  endtask

  // Drop valid and wait for every predicted result to come back. Each event
  // yields exactly one result, so an empty backlog means nothing in flight;
  // an extra wait after it covers the two-stage pipe anyway.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Send one event beat. Beats go out in bursts; between bursts valid drops
  // for a random gap, and about a quarter of bursts follow with no gap at all.
  task automatic send_event(input thc_pkg::req_t req, input int adc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_adc_sample <= thc_pkg::ADC_W'(adc);
    // beat is taken at the first edge with stall low; payload held till then
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly ticks with a drifting temperature, so that averaging, hysteresis
  // and idle power-off all get exercised; presses are sprinkled in so that
  // setting mode, its timeout and manual power toggles keep recurring.
  task automatic random_events(input int count);
    int            k, pick, adc;
    thc_pkg::req_t req;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 84)      req = thc_pkg::REQ_TICK;
      else if (pick < 90) req = thc_pkg::REQ_UP;
      else if (pick < 96) req = thc_pkg::REQ_DOWN;
      else                req = thc_pkg::REQ_POWER;

      if ($urandom_range(0, 99) < 3) begin
        water = $urandom_range(0, 255);
      end else begin
        water = water + int'($urandom_range(0, 6)) - 3;
        if (water < 0) water = 0;
        if (water > 130) water = 130;
      end
      adc = water * 4 + int'($urandom_range(0, 3));
      if (adc > 1023) adc = 1023;
      // occasional noise sample anywhere in the converter range
      if ($urandom_range(0, 99) < 5) adc = $urandom_range(0, 1023);

      send_event(req, adc);
    end
  endtask

  initial begin
    int k;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass on reset settings (setpoint 35..75, band 5).
    // Ticks while idle: timer stopped, display shows setpoint.
    send_event(thc_pkg::REQ_TICK, 0);
    send_event(thc_pkg::REQ_TICK, 1023);
    // First press only enters setting mode, then step up into the max limit.
    send_event(thc_pkg::REQ_UP, 10'h155);
    send_event(thc_pkg::REQ_UP, 10'h2AA);
    send_event(thc_pkg::REQ_UP, 10'h3FF);
    send_event(thc_pkg::REQ_UP, 10'h000);
    send_event(thc_pkg::REQ_UP, 10'h100);
    // Step down all the way and one more against the min limit.
    for (k = 0; k < 9; k++) send_event(thc_pkg::REQ_DOWN, 10'h0F0);
    send_event(thc_pkg::REQ_TICK, 10'h0F0);
    // Power press leaves setting mode; a hot sample starts the cooler.
    send_event(thc_pkg::REQ_POWER, 400);
    send_event(thc_pkg::REQ_TICK, 0);
    send_event(thc_pkg::REQ_TICK, 0);
    // Up while on is ignored; power off clears drives and LEDs.
    send_event(thc_pkg::REQ_UP, 0);
    send_event(thc_pkg::REQ_POWER, 0);
    // Power on straight from idle with a cold sample starts the heater.
    send_event(thc_pkg::REQ_POWER, 0);
    send_event(thc_pkg::REQ_TICK, 4);
    send_event(thc_pkg::REQ_POWER, 8);
    drain();

    // Typical settings with short timers.
    apply_settings(35, 75, 5, 1, 15, 3, 40);
    random_events(300);
    drain();

    // Low extremes: every timer fires on its first tick, zero band.
    apply_settings(0, 99, 0, 1, 1, 1, 1);
    random_events(250);
    drain();

    // High extremes: timers effectively never fire, band of 20.
    apply_settings(99, 99, 20, 255, 65535, 255, 65535);
    random_events(120);
    drain();

    apply_settings(20, 90, 3, 2, 30, 5, 100);
    random_events(400);
    drain();

    // Narrow setpoint window with a wide band.
    apply_settings(50, 60, 10, 3, 8, 2, 20);
    random_events(255);
    drain();

    if (mismatches == 0 && backlog == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
